// ----- sv/wdw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package wdw_pkg;

    localparam int WINDOW_LEN = 10;
    localparam int SAMPLE_W   = 8;
    localparam int TOP_COUNT  = 4;
    localparam int TOP_LOG    = $clog2(TOP_COUNT);
    localparam int IDX_W      = $clog2(WINDOW_LEN);
    localparam int SUM_W      = SAMPLE_W + TOP_LOG;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [SUM_W-1:0]    t_sum;

    localparam t_sample RESET_FILL = t_sample'(127);
    localparam t_idx    LAST_IDX   = t_idx'(WINDOW_LEN - 1);

    typedef struct packed {
        logic clear;
        logic insert;
    } t_ins_ctrl;

endpackage

`default_nettype wire

// ----- sv/wdw_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface wdw_in_if;
    logic             valid;
    logic             ready;
    wdw_pkg::t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ----- sv/wdw_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface wdw_out_if;
    logic             valid;
    logic             ready;
    wdw_pkg::t_sample level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

`default_nettype wire

// ----- sv/wdw_topk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wdw_topk (
    input  wire                logic       i_clk,
    input  wdw_pkg::t_ins_ctrl i_ctrl,
    input  wdw_pkg::t_sample   i_value,
    output wdw_pkg::t_sample   o_level
);

    wdw_pkg::t_sample r_best [wdw_pkg::TOP_COUNT];
    wdw_pkg::t_sample n_best [wdw_pkg::TOP_COUNT];
    logic [wdw_pkg::TOP_COUNT-1:0] w_gt;
    wdw_pkg::t_sum w_sum;

    // one insertion step into the descending list
    always_comb begin
        for (int j = 0; j < wdw_pkg::TOP_COUNT; j++) begin
            w_gt[j] = i_value > r_best[j];
        end
        for (int j = 0; j < wdw_pkg::TOP_COUNT; j++) begin
            if (!w_gt[j]) begin
                n_best[j] = r_best[j];
            end else if (j == 0) begin
                n_best[j] = i_value;
            end else if (!w_gt[j-1]) begin
                n_best[j] = i_value;
            end else begin
                n_best[j] = r_best[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < wdw_pkg::TOP_COUNT; j++) begin
            if (i_ctrl.clear) begin
                r_best[j] <= '0;
            end else if (i_ctrl.insert) begin
                r_best[j] <= n_best[j];
            end
        end
    end

    always_comb begin
        w_sum = '0;
        for (int j = 0; j < wdw_pkg::TOP_COUNT; j++) begin
            w_sum = w_sum + wdw_pkg::t_sum'(r_best[j]);
        end
    end

    assign o_level = w_sum[wdw_pkg::SUM_W-1:wdw_pkg::TOP_LOG];

endmodule

`default_nettype wire

// ----- sv/window_top_four_level_core.sv -----
// a taken sample starts a scan of the window; the level then waits in S_HOLD to be loaded
// a new sample is taken only in S_IDLE, after the last level was loaded; the scan drives
//   one insertion step of four comparators over the ten window slots one per cycle
// the output register holds a finished level until taken
// reset (synchronous, active low): every window slot to 127, write index to 0
`timescale 1ns / 1ps
`default_nettype none

module window_top_four_level_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    wdw_in_if.sink      i_in,
    wdw_out_if.source   o_out
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state r_state, n_state;
    wdw_pkg::t_sample r_win [wdw_pkg::WINDOW_LEN];
    wdw_pkg::t_idx r_wr_idx;
    wdw_pkg::t_idx r_scan_idx;
    logic r_out_valid;
    wdw_pkg::t_sample r_level;
    wdw_pkg::t_sample w_level;
    wdw_pkg::t_ins_ctrl w_ctrl;
    logic w_in_take;
    logic w_out_load;

    assign i_in.ready  = r_state == S_IDLE;
    assign w_in_take   = i_in.valid && i_in.ready;
    assign w_out_load  = (r_state == S_HOLD) && (!r_out_valid || o_out.ready);
    assign o_out.valid = r_out_valid;
    assign o_out.level = r_level;

    assign w_ctrl.clear  = w_in_take;
    assign w_ctrl.insert = r_state == S_SCAN;

    wdw_topk u_topk (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_value (r_win[r_scan_idx]),
        .o_level (w_level)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_scan_idx == wdw_pkg::LAST_IDX) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_idx    <= '0;
            r_scan_idx  <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < wdw_pkg::WINDOW_LEN; k++) begin
                r_win[k] <= wdw_pkg::RESET_FILL;
            end
        end else begin
            r_state <= n_state;
            if (w_in_take) begin
                r_win[r_wr_idx] <= i_in.sample;
                r_wr_idx        <= (r_wr_idx == wdw_pkg::LAST_IDX) ? '0 : r_wr_idx + 1'b1;
                r_scan_idx      <= '0;
            end else if (r_state == S_SCAN) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_level <= w_level;
        end
    end

endmodule

`default_nettype wire
